// ----- design/ir_pulse_duration_capture_unit_defines.svh -----
// assertion macros for the ir pulse duration capture unit
// no dependencies; included by files that carry concurrent assertions
`ifndef IR_PULSE_DURATION_CAPTURE_UNIT_DEFINES_SVH
`define IR_PULSE_DURATION_CAPTURE_UNIT_DEFINES_SVH

// same-cycle implication, checking off while reset is active
`define IPDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checking off while reset is active
`define IPDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ipdc_pkg.sv -----
// shared types and constants of the ir pulse duration capture unit
// no dependencies; imported by ir_pulse_duration_capture_unit and its test bench
package ipdc_pkg;

    localparam int DUR_W     = 16;
    localparam int INDEX_W   = 7;
    localparam int CFG_W     = 16;
    localparam int ELAPSED_W = 27;
    // timeout limits in ticks, clipped to one above the elapsed cap
    localparam int LIMIT_W   = ELAPSED_W + 1;

    localparam logic [ELAPSED_W-1:0] ELAPSED_CAP = {ELAPSED_W{1'b1}};

    // request action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_BEGIN_TIMEOUT = 1'b0,
        CFG_END_TIMEOUT   = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        CAUSE_RUNNING       = 2'd0,
        CAUSE_END_TIMEOUT   = 2'd1,
        CAUSE_BUFFER_FULL   = 2'd2,
        CAUSE_BEGIN_TIMEOUT = 2'd3
    } end_cause_t;

    typedef struct packed {
        logic action;
        logic ir_level;
    } req_t;

    typedef struct packed {
        logic [DUR_W-1:0]   duration;
        logic [INDEX_W-1:0] index;
        logic               has_duration;
        logic               is_last;
        end_cause_t         end_cause;
    } res_t;

endpackage

// ----- design/ir_pulse_duration_capture_unit.sv -----
// ir pulse duration capture unit: measures mark/space lengths of a sampled ir receiver
// depends on ipdc_pkg and ir_pulse_duration_capture_unit_defines.svh
//
//   channel   | direction | handshake              | payload
//   ----------+-----------+------------------------+-------------------------------
//   req       | in        | req_valid / req_stall  | req_t: action, ir_level
//   res       | out       | res_valid / res_stall  | res_t: duration, index, flags
//   cfg       | in        | cfg_write_en           | cfg_index, cfg_wdata
//
// one request per cycle sustained while results are not stalled; a request is held in the input register
// while the decision logic settles, and its result is then registered in the output register
// the critical path is the 27-bit tick counter increment and the limit compare
// timeout limits in ticks are formed by one multiply at the configuration write
// reset: idle, no capture running, limits at 2000 ms and 30 ms worth of ticks
// a stalled result holds the output register; the input register then holds too
`include "ir_pulse_duration_capture_unit_defines.svh"

module ir_pulse_duration_capture_unit
    import ipdc_pkg::*;
#(
    parameter int BUFFER_DEPTH = 128,
    parameter int DURATION_MAX = 65535,
    parameter int TICKS_PER_MS = 1000
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         req_valid,
    output logic                         req_stall,
    input  req_t                         req,

    output logic                         res_valid,
    input  logic                         res_stall,
    output res_t                         res,

    input  logic                         cfg_write_en,
    input  cfg_index_t                   cfg_index,
    input  logic [CFG_W-1:0]             cfg_wdata
);

    // count of recorded durations reaches BUFFER_DEPTH itself
    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
    localparam int TPM_W  = $clog2(TICKS_PER_MS + 1);
    localparam int PROD_W = CFG_W + TPM_W;
    localparam int MUL_W  = (PROD_W > LIMIT_W) ? PROD_W : LIMIT_W;

    localparam longint BEGIN_RST_TICKS = 64'(2000) * 64'(TICKS_PER_MS);
    localparam longint END_RST_TICKS   = 64'(30) * 64'(TICKS_PER_MS);
    localparam longint CAP_LONG        = longint'(ELAPSED_CAP);

    // a limit past the counter cap never fires, so clip it to cap plus one
    localparam logic [LIMIT_W-1:0] BEGIN_LIMIT_RST = (BEGIN_RST_TICKS > CAP_LONG) ?
        LIMIT_W'(CAP_LONG + 1) : LIMIT_W'(BEGIN_RST_TICKS);
    localparam logic [LIMIT_W-1:0] END_LIMIT_RST = (END_RST_TICKS > CAP_LONG) ?
        LIMIT_W'(CAP_LONG + 1) : LIMIT_W'(END_RST_TICKS);

    localparam logic [DUR_W-1:0]     DUR_MAX_VAL = DUR_W'(DURATION_MAX);
    localparam logic [ELAPSED_W-1:0] DUR_MAX_EXT = ELAPSED_W'(DURATION_MAX);
    localparam logic [CNT_W-1:0]     DEPTH_VAL   = CNT_W'(BUFFER_DEPTH);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SEARCH,
        PH_COLLECT
    } phase_t;

    // configuration: limits held in ticks
    logic [LIMIT_W-1:0] begin_limit_reg;
    logic [LIMIT_W-1:0] end_limit_reg;
    logic [MUL_W-1:0]   cfg_product;
    logic [LIMIT_W-1:0] cfg_limit;

    // input register
    logic               in_valid_reg;
    req_t               in_data_reg;

    // capture state
    phase_t             phase_reg, phase_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic               prev_level_reg, prev_level_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    // output register
    logic               out_valid_reg;
    res_t               out_data_reg;

    logic               advance;
    logic               emit;
    res_t               result;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic [CNT_W-1:0]   count_inc;
    logic [DUR_W-1:0]   dur_sat;

    // ---------------------------------------------------------------
    // configuration writes: the multiply sits between port and limit register
    // ---------------------------------------------------------------
    assign cfg_product = MUL_W'(cfg_wdata) * MUL_W'(TICKS_PER_MS);
    assign cfg_limit   = (cfg_product > MUL_W'(ELAPSED_CAP)) ?
                         LIMIT_W'(MUL_W'(ELAPSED_CAP) + MUL_W'(1)) : cfg_product[LIMIT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            begin_limit_reg <= BEGIN_LIMIT_RST;
            end_limit_reg   <= END_LIMIT_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_BEGIN_TIMEOUT: begin_limit_reg <= cfg_limit;
                CFG_END_TIMEOUT:   end_limit_reg   <= cfg_limit;
                default:           begin_limit_reg <= begin_limit_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // handshake: the held request moves on whenever the output slot is free
    // or is being drained this cycle
    // ---------------------------------------------------------------
    assign advance   = in_valid_reg && (!out_valid_reg || !res_stall);
    assign req_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            in_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            in_data_reg <= req;
        end
    end

    // ---------------------------------------------------------------
    // decision logic for the held request
    // ---------------------------------------------------------------
    assign elapsed_inc = (elapsed_reg == ELAPSED_CAP) ? elapsed_reg : elapsed_reg + 1'b1;
    assign count_inc   = count_reg + 1'b1;
    // duration in ticks, clipped to the configured maximum
    assign dur_sat     = (elapsed_inc > DUR_MAX_EXT) ? DUR_MAX_VAL : elapsed_inc[DUR_W-1:0];

    always_comb
    begin
        phase_next      = phase_reg;
        elapsed_next    = elapsed_reg;
        prev_level_next = prev_level_reg;
        count_next      = count_reg;
        emit            = 1'b0;
        result          = '{duration: '0, index: '0, has_duration: 1'b0,
                            is_last: 1'b0, end_cause: CAUSE_RUNNING};

        if (in_data_reg.action == ACT_START)
        begin
            // start always restarts, even in the middle of a capture
            phase_next      = PH_SEARCH;
            elapsed_next    = '0;
            prev_level_next = 1'b1;
            count_next      = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_SEARCH:
                begin
                    if (in_data_reg.ir_level)
                    begin
                        // first mark opens collection
                        phase_next      = PH_COLLECT;
                        elapsed_next    = '0;
                        prev_level_next = 1'b1;
                    end
                    else
                    begin
                        elapsed_next = elapsed_inc;
                        if ({1'b0, elapsed_inc} > begin_limit_reg)
                        begin
                            phase_next       = PH_IDLE;
                            emit             = 1'b1;
                            result.is_last   = 1'b1;
                            result.end_cause = CAUSE_BEGIN_TIMEOUT;
                        end
                    end
                end
                PH_COLLECT:
                begin
                    result.duration     = dur_sat;
                    result.index        = INDEX_W'(count_reg);
                    result.has_duration = 1'b1;
                    if (in_data_reg.ir_level != prev_level_reg)
                    begin
                        // level change closes the running mark or space
                        emit            = 1'b1;
                        count_next      = count_inc;
                        prev_level_next = in_data_reg.ir_level;
                        elapsed_next    = '0;
                        if (count_inc >= DEPTH_VAL)
                        begin
                            phase_next       = PH_IDLE;
                            result.is_last   = 1'b1;
                            result.end_cause = CAUSE_BUFFER_FULL;
                        end
                    end
                    else if (!in_data_reg.ir_level && ({1'b0, elapsed_inc} > end_limit_reg))
                    begin
                        // long space ends the capture; its length is the last duration
                        emit             = 1'b1;
                        count_next       = count_inc;
                        elapsed_next     = elapsed_inc;
                        phase_next       = PH_IDLE;
                        result.is_last   = 1'b1;
                        result.end_cause = CAUSE_END_TIMEOUT;
                    end
                    else
                    begin
                        elapsed_next = elapsed_inc;
                    end
                end
                default:
                begin
                    // ticks while idle are dropped
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // state and output register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            elapsed_reg    <= '0;
            prev_level_reg <= 1'b1;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg      <= phase_next;
                elapsed_reg    <= elapsed_next;
                prev_level_reg <= prev_level_next;
                count_reg      <= count_next;
            end
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_data_reg <= result;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_data_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `IPDC_ASSERT_NEXT(a_last_goes_idle, clk, rst_n,
        advance && emit && result.is_last, phase_reg == PH_IDLE,
        "capture did not end after its last result")
    `IPDC_ASSERT_NOW(a_count_bounded, clk, rst_n,
        1'b1, count_reg <= DEPTH_VAL,
        "recorded count beyond buffer depth")
    `IPDC_ASSERT_NOW(a_no_dur_fields, clk, rst_n,
        res_valid && !res.has_duration,
        res.end_cause == CAUSE_BEGIN_TIMEOUT && res.duration == '0 && res.index == '0,
        "result without duration is not a clean beginning timeout")
    `IPDC_ASSERT_NOW(a_running_not_last, clk, rst_n,
        res_valid && !res.is_last, res.has_duration && res.end_cause == CAUSE_RUNNING,
        "non-final result carries an end cause")
    `IPDC_ASSERT_NOW(a_stall_needs_held, clk, rst_n,
        req_stall, in_valid_reg && out_valid_reg && res_stall,
        "request stalled without a blocked output")

endmodule

// ----- tb/ir_pulse_duration_capture_unit_test.sv -----
`timescale 1ns / 100ps
// self-checking bench for ir_pulse_duration_capture_unit: directed and random captures,
// results checked against an in-bench pulse predictor held by a small scoreboard class
// depends on ipdc_pkg and the ir_pulse_duration_capture_unit rtl
module ir_pulse_duration_capture_unit_test
    import ipdc_pkg::*;
;

    localparam int BUFFER_DEPTH  = 128;
    localparam int DURATION_MAX  = 65535;
    localparam int TICKS_PER_MS  = 1000;
    // two register stages between request and result, plus margin
    localparam int SETTLE_CYCLES = 8;
    // watchdog limit for a clean run under the longest gaps and stalls
    localparam int CYCLE_LIMIT   = 1000000;
    // accepted, non-ignored requests per random phase
    localparam int PHASE_ITEMS   = 325;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SEARCH,
        PH_COLLECT
    } capture_phase_e;

    // pulse predictor plus the queue of pulse records it still owes the checker
    class capture_scoreboard;
        logic [CFG_W-1:0]     begin_limit_ms = 16'd2000;
        logic [CFG_W-1:0]     end_limit_ms   = 16'd30;
        capture_phase_e       phase          = PH_IDLE;
        logic [ELAPSED_W-1:0] elapsed        = '0;
        logic                 prev_level     = 1'b1;
        int unsigned          recorded_count = 0;
        res_t                 pulses_due[$];
        int                   failures       = 0;
        int                   active_items   = 0;

        function void set_register(cfg_index_t idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_BEGIN_TIMEOUT: begin_limit_ms = value;
                CFG_END_TIMEOUT:   end_limit_ms   = value;
                default: ;
            endcase
        endfunction

        function void queue_pulse(logic [DUR_W-1:0] dur, logic [INDEX_W-1:0] idx,
                                  logic has, logic last, end_cause_t cause);
            res_t p;
            p.duration     = dur;
            p.index        = idx;
            p.has_duration = has;
            p.is_last      = last;
            p.end_cause    = cause;
            pulses_due.push_back(p);
        endfunction

        function void bump_elapsed();
            if (elapsed != ELAPSED_CAP)
                elapsed++;
        endfunction

        function void note_request(req_t item);
            longint unsigned  limit;
            logic [DUR_W-1:0] dur;
            logic [INDEX_W-1:0] idx;
            if (item.action == ACT_START)
            begin
                // restart from anywhere, no pulse record
                active_items++;
                phase          = PH_SEARCH;
                elapsed        = '0;
                prev_level     = 1'b1;
                recorded_count = 0;
                return;
            end
            if (phase != PH_IDLE)
                active_items++;
            case (phase)
                PH_SEARCH:
                begin
                    limit = 64'(begin_limit_ms) * 64'(TICKS_PER_MS);
                    if (item.ir_level)
                    begin
                        phase      = PH_COLLECT;
                        elapsed    = '0;
                        prev_level = 1'b1;
                    end
                    else
                    begin
                        bump_elapsed();
                        if (64'(elapsed) > limit)
                        begin
                            phase = PH_IDLE;
                            queue_pulse('0, '0, 1'b0, 1'b1, CAUSE_BEGIN_TIMEOUT);
                        end
                    end
                end
                PH_COLLECT:
                begin
                    limit = 64'(end_limit_ms) * 64'(TICKS_PER_MS);
                    idx   = INDEX_W'(recorded_count);
                    bump_elapsed();
                    dur = (elapsed > ELAPSED_W'(DURATION_MAX)) ? DUR_W'(DURATION_MAX)
                                                                : elapsed[DUR_W-1:0];
                    if (item.ir_level != prev_level)
                    begin
                        recorded_count++;
                        prev_level = item.ir_level;
                        elapsed    = '0;
                        // a change that fills the buffer reports buffer full
                        if (recorded_count >= BUFFER_DEPTH)
                        begin
                            phase = PH_IDLE;
                            queue_pulse(dur, idx, 1'b1, 1'b1, CAUSE_BUFFER_FULL);
                        end
                        else
                            queue_pulse(dur, idx, 1'b1, 1'b0, CAUSE_RUNNING);
                    end
                    else if (!item.ir_level && 64'(elapsed) > limit)
                    begin
                        // ending timeout wins even when it also fills the buffer
                        recorded_count++;
                        phase = PH_IDLE;
                        queue_pulse(dur, idx, 1'b1, 1'b1, CAUSE_END_TIMEOUT);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_pulse(res_t got);
            res_t want;
            if (pulses_due.size() == 0)
            begin
                $error("unexpected result: duration %0d index %0d", got.duration, got.index);
                failures++;
                return;
            end
            want = pulses_due.pop_front();
            if (got.duration !== want.duration)
            begin
                $error("duration: expected %0d, got %0d", want.duration, got.duration);
                failures++;
            end
            if (got.index !== want.index)
            begin
                $error("index: expected %0d, got %0d", want.index, got.index);
                failures++;
            end
            if (got.has_duration !== want.has_duration)
            begin
                $error("has_duration: expected %0d, got %0d", want.has_duration,
                       got.has_duration);
                failures++;
            end
            if (got.is_last !== want.is_last)
            begin
                $error("is_last: expected %0d, got %0d", want.is_last, got.is_last);
                failures++;
            end
            if (got.end_cause !== want.end_cause)
            begin
                $error("end_cause: expected %0d, got %0d", want.end_cause, got.end_cause);
                failures++;
            end
        endfunction
    endclass

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             req_valid    = 1'b0;
    logic             req_stall;
    req_t             req          = '0;
    logic             res_valid;
    logic             res_stall    = 1'b0;
    res_t             res;
    logic             cfg_write_en = 1'b0;
    cfg_index_t       cfg_index    = CFG_BEGIN_TIMEOUT;
    logic [CFG_W-1:0] cfg_wdata    = '0;

    capture_scoreboard sb = new();

    // idle_on off gives back-to-back requests and no result stalls
    bit idle_on     = 1'b1;
    int stall_left  = 0;
    int cycle_count = 0;

    ir_pulse_duration_capture_unit #(
        .BUFFER_DEPTH(BUFFER_DEPTH),
        .DURATION_MAX(DURATION_MAX),
        .TICKS_PER_MS(TICKS_PER_MS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res         (res),
        .cfg_write_en(cfg_write_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    always #5 clk = ~clk;

    // watchdog: a hung handshake or a missing result ends here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: check each accepted pulse record, then stall a random while
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                sb.check_pulse(res);
                stall_left = idle_on ? $urandom_range(0, 10) : 0;
            end
            if (stall_left > 0)
            begin
                res_stall <= 1'b1;
                stall_left--;
            end
            else
                res_stall <= 1'b0;
        end
    end

    // one request: optional gap with valid low, then hold until accepted
    task automatic send_request(logic act, logic lvl);
        int   gap;
        req_t item;
        item.action   = act;
        item.ir_level = lvl;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sb.note_request(item);
    endtask

    // n sample ticks at one level
    task automatic send_run(logic lvl, int n);
        repeat (n) send_request(ACT_TICK, lvl);
    endtask

    // n ticks alternating space, mark, space, ... one level change each
    task automatic send_toggles(int n);
        for (int i = 0; i < n; i++)
            send_request(ACT_TICK, (i % 2) == 1);
    endtask

    task automatic send_start();
        send_request(ACT_START, 1'($urandom_range(0, 1)));
    endtask

    // drop valid, wait for every owed pulse record, then let the pipe empty
    task automatic let_drain();
        req_valid <= 1'b0;
        while (sb.pulses_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // both timeout registers on back-to-back write cycles
    task automatic configure(logic [CFG_W-1:0] begin_ms, logic [CFG_W-1:0] end_ms);
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_BEGIN_TIMEOUT;
        cfg_wdata    <= begin_ms;
        @(posedge clk);
        sb.set_register(CFG_BEGIN_TIMEOUT, begin_ms);
        cfg_index <= CFG_END_TIMEOUT;
        cfg_wdata <= end_ms;
        @(posedge clk);
        sb.set_register(CFG_END_TIMEOUT, end_ms);
        cfg_write_en <= 1'b0;
    endtask

    // one capture: short search, a mark, alternating runs, then some ending
    task automatic random_capture(int unsigned end_ms);
        int   runs;
        int   len;
        logic lvl;
        idle_on = ($urandom_range(0, 3) != 0);
        // stray ticks, ignored when no capture is running
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3)) send_request(ACT_TICK, 1'($urandom_range(0, 1)));
        send_start();
        // search spaces; with a zero beginning timeout the first one ends it
        repeat ($urandom_range(0, 3)) send_request(ACT_TICK, 1'b0);
        send_run(1'b1, $urandom_range(1, 4));
        lvl  = 1'b1;
        runs = ($urandom_range(0, 11) == 0) ? $urandom_range(120, 140) : $urandom_range(1, 14);
        for (int i = 0; i < runs; i++)
        begin
            lvl = ~lvl;
            if (!lvl && end_ms == 0)
                len = 1;
            else if ($urandom_range(0, 7) == 0)
                len = $urandom_range(5, 40);
            else
                len = $urandom_range(1, 3);
            send_run(lvl, len);
        end
        case ($urandom_range(0, 2))
            // a space just long enough to time out
            0: if (end_ms == 0) send_run(1'b0, 2);
            // broken tail of random ticks
            1: repeat ($urandom_range(1, 5)) send_request(ACT_TICK, 1'($urandom_range(0, 1)));
            // otherwise the next start cuts the capture short
            default: ;
        endcase
    endtask

    task automatic random_phase(logic [CFG_W-1:0] begin_ms, logic [CFG_W-1:0] end_ms);
        int target;
        configure(begin_ms, end_ms);
        target = sb.active_items + PHASE_ITEMS;
        while (sb.active_items < target)
            random_capture(end_ms);
        let_drain();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ticks before any start are ignored
        send_request(ACT_TICK, 1'b1);
        send_request(ACT_TICK, 1'b0);

        // reset limits, then a restart in the middle of a capture
        send_request(ACT_START, 1'b1);
        send_run(1'b1, 3);
        send_run(1'b0, 2);
        send_run(1'b1, 1);
        send_request(ACT_START, 1'b0);
        send_run(1'b1, 1);
        send_run(1'b0, 1);
        let_drain();

        // zero timeouts: first search space ends at once, second space ends collection
        configure(16'd0, 16'd0);
        send_start();
        send_run(1'b0, 1);
        send_start();
        send_run(1'b1, 2);
        send_run(1'b0, 2);
        send_run(1'b1, 1);
        let_drain();

        // beginning timeout after a full millisecond of space; the long run
        // goes back to back
        configure(16'd1, 16'd66);
        idle_on = 1'b0;
        send_start();
        send_run(1'b0, TICKS_PER_MS + 1);
        let_drain();

        // buffer full on a change, then ending timeout on the filling space
        configure(16'd0, 16'd0);
        idle_on = 1'b1;
        send_start();
        send_run(1'b1, 1);
        send_toggles(BUFFER_DEPTH);
        send_run(1'b0, 1);
        send_start();
        send_run(1'b1, 1);
        send_toggles(BUFFER_DEPTH - 1);
        send_run(1'b0, 1);
        let_drain();

        // largest register values: nothing times out
        configure(16'hFFFF, 16'hFFFF);
        send_start();
        send_run(1'b0, 5);
        send_run(1'b1, 4);
        send_run(1'b0, 50);
        send_run(1'b1, 2);
        send_start();
        let_drain();

        random_phase(16'd0, 16'd0);
        random_phase(16'd1, 16'd0);
        random_phase(16'd0, 16'd1);
        random_phase(16'hFFFF, 16'hFFFF);

        // catch any stray result after the last expected one
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pulses_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
